>>> design/cbu_pkg.sv
package cbu_pkg;

  localparam int NUM_CH   = 4;
  localparam int CH_ALPHA = 3;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SRC_FACTOR = 2'd0;
  localparam logic [1:0] REG_DST_FACTOR = 2'd1;
  localparam logic [1:0] REG_BLEND_OP   = 2'd2;
  localparam logic [1:0] REG_CONSTANT   = 2'd3;

  // factor modes
  localparam logic [3:0] FM_ZERO        = 4'd0;
  localparam logic [3:0] FM_ONE         = 4'd1;
  localparam logic [3:0] FM_SRC_COL     = 4'd2;
  localparam logic [3:0] FM_INV_SRC_COL = 4'd3;
  localparam logic [3:0] FM_SRC_A       = 4'd4;
  localparam logic [3:0] FM_INV_SRC_A   = 4'd5;
  localparam logic [3:0] FM_DST_A       = 4'd6;
  localparam logic [3:0] FM_INV_DST_A   = 4'd7;
  localparam logic [3:0] FM_DST_COL     = 4'd8;
  localparam logic [3:0] FM_INV_DST_COL = 4'd9;
  localparam logic [3:0] FM_CONST       = 4'd10;
  localparam logic [3:0] FM_INV_CONST   = 4'd11;

  // combine operations
  localparam logic [1:0] OP_SAT_ADD   = 2'd0;
  localparam logic [1:0] OP_MAX_COLOR = 2'd1;
  localparam logic [1:0] OP_MIN_COLOR = 2'd2;

  localparam logic [3:0] RST_SRC_FACTOR = FM_SRC_A;
  localparam logic [3:0] RST_DST_FACTOR = FM_INV_SRC_A;
  localparam logic [7:0] FULL           = 8'd255;

  typedef logic [NUM_CH-1:0][7:0]  ch8_t;
  typedef logic [NUM_CH-1:0][15:0] ch16_t;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pix_out_t;

  typedef struct packed {
    logic [3:0] src_factor_mode;
    logic [3:0] dst_factor_mode;
    logic [1:0] blend_op;
    logic [7:0] blend_constant;
  } cfg_t;

  // after factor selection
  typedef struct packed {
    ch8_t src;
    ch8_t dst;
    ch8_t fs;
    ch8_t fd;
  } fac_t;

  // after multiplication
  typedef struct packed {
    ch8_t  src;
    ch8_t  dst;
    ch16_t ps;
    ch16_t pd;
  } prod_t;

  // after the divide by 255
  typedef struct packed {
    ch8_t src;
    ch8_t dst;
    ch8_t ss;
    ch8_t ds;
  } scaled_t;

  function automatic logic [7:0] pick_factor(input logic [3:0] mode, input logic [7:0] s,
                                             input logic [7:0] d, input logic [7:0] sa,
                                             input logic [7:0] da, input logic [7:0] k);
    logic [7:0] f;
    unique case (mode)
      FM_ZERO:        f = 8'd0;
      FM_ONE:         f = FULL;
      FM_SRC_COL:     f = s;
      FM_INV_SRC_COL: f = FULL - s;
      FM_SRC_A:       f = sa;
      FM_INV_SRC_A:   f = FULL - sa;
      FM_DST_A:       f = da;
      FM_INV_DST_A:   f = FULL - da;
      FM_DST_COL:     f = d;
      FM_INV_DST_COL: f = FULL - d;
      FM_CONST:       f = k;
      FM_INV_CONST:   f = FULL - k;
      default:        f = FULL;
    endcase
    return f;
  endfunction

  // exact floor(x / 255) for any product of two 8-bit values
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + {8'd0, x[15:8]} + 16'd1;
    return t[15:8];
  endfunction

endpackage

>>> design/cbu_factor.sv
module cbu_factor import cbu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    pix_valid,
  output logic    pix_ready,
  input  pix_in_t pix,
  output logic    fac_valid,
  input  logic    fac_ready,
  output fac_t    fac
);

  ch8_t s;
  ch8_t d;
  fac_t fac_next;

  assign s = {pix.src_alpha, pix.src_blue, pix.src_green, pix.src_red};
  assign d = {pix.dst_alpha, pix.dst_blue, pix.dst_green, pix.dst_red};

  always_comb begin
    fac_next.src = s;
    fac_next.dst = d;
    for (int i = 0; i < NUM_CH; i++) begin
      fac_next.fs[i] = pick_factor(cfg.src_factor_mode, s[i], d[i], s[CH_ALPHA],
                                   d[CH_ALPHA], cfg.blend_constant);
      fac_next.fd[i] = pick_factor(cfg.dst_factor_mode, s[i], d[i], s[CH_ALPHA],
                                   d[CH_ALPHA], cfg.blend_constant);
    end
  end

  // load when the slot is empty or its transaction leaves this cycle
  assign pix_ready = !fac_valid || fac_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fac_valid <= 1'b0;
    end else if (pix_ready) begin
      fac_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ready && pix_valid) begin
      fac <= fac_next;
    end
  end

endmodule

>>> design/cbu_scale.sv
module cbu_scale import cbu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fac_valid,
  output logic    fac_ready,
  input  fac_t    fac,
  output logic    scl_valid,
  input  logic    scl_ready,
  output scaled_t scl
);

  logic  prd_valid;
  logic  prd_ready;
  prod_t prd;

  // multiply stage
  assign fac_ready = !prd_valid || prd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prd_valid <= 1'b0;
    end else if (fac_ready) begin
      prd_valid <= fac_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fac_ready && fac_valid) begin
      prd.src <= fac.src;
      prd.dst <= fac.dst;
      for (int i = 0; i < NUM_CH; i++) begin
        prd.ps[i] <= {8'd0, fac.src[i]} * {8'd0, fac.fs[i]};
        prd.pd[i] <= {8'd0, fac.dst[i]} * {8'd0, fac.fd[i]};
      end
    end
  end

  // divide-by-255 stage
  assign prd_ready = !scl_valid || scl_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_valid <= 1'b0;
    end else if (prd_ready) begin
      scl_valid <= prd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prd_ready && prd_valid) begin
      scl.src <= prd.src;
      scl.dst <= prd.dst;
      for (int i = 0; i < NUM_CH; i++) begin
        scl.ss[i] <= div255(prd.ps[i]);
        scl.ds[i] <= div255(prd.pd[i]);
      end
    end
  end

endmodule

>>> design/cbu_combine.sv
module cbu_combine import cbu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic [1:0] blend_op,
  input  logic     scl_valid,
  output logic     scl_ready,
  input  scaled_t  scl,
  output logic     res_valid,
  input  logic     res_ready,
  output pix_out_t res
);

  ch8_t r;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      logic [8:0] sum;
      sum = {1'b0, scl.ss[i]} + {1'b0, scl.ds[i]};
      case (blend_op)
        OP_SAT_ADD:   r[i] = sum[8] ? FULL : sum[7:0];
        OP_MAX_COLOR: r[i] = (scl.src[i] > scl.dst[i]) ? scl.src[i] : scl.dst[i];
        OP_MIN_COLOR: r[i] = (scl.src[i] < scl.dst[i]) ? scl.src[i] : scl.dst[i];
        default:      r[i] = scl.ss[i];
      endcase
    end
  end

  assign scl_ready = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (scl_ready) begin
      res_valid <= scl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scl_ready && scl_valid) begin
      res <= '{out_red: r[0], out_green: r[1], out_blue: r[2], out_alpha: r[3]};
    end
  end

endmodule

>>> design/color_blend_unit_core.sv
// Color blend unit: per-pixel output merger.
// Pixel channel (pix_valid / pix_ready / pix) carries one transaction per
// fragment: the source pixel and the destination pixel read from the target.
// Result channel (res_valid / res_ready / res) returns the blended pixel.
// Each side is scaled by its selected factor as floor(c * f / 255), then the
// sides combine: saturating add, max/min of unscaled colors, or scaled src.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register
// per cycle; write it only while no transaction is in flight.
// Four register stages (factor select, multiply, divide by 255, combine);
// each stage can hold one transaction; a pixel passes them in turn to res.
// Throughput: one pixel per cycle while res_ready stays high.
// When the receiver drops res_ready, the stages fill up one by one and
// pix_ready falls once all four hold data; nothing is lost or repeated.
// Reset clears all stage valid bits and loads the default blend setup:
// source factor source-alpha, destination factor one-minus-source-alpha,
// saturating add, constant zero.
module color_blend_unit_core import cbu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pix_valid,
  output logic       pix_ready,
  input  pix_in_t    pix,
  output logic       res_valid,
  input  logic       res_ready,
  output pix_out_t   res,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t    cfg;
  logic    fac_valid;
  logic    fac_ready;
  fac_t    fac;
  logic    scl_valid;
  logic    scl_ready;
  scaled_t scl;

  // Hold configuration; write the selected register, masked to its width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_factor_mode <= RST_SRC_FACTOR;
      cfg.dst_factor_mode <= RST_DST_FACTOR;
      cfg.blend_op        <= OP_SAT_ADD;
      cfg.blend_constant  <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_FACTOR: cfg.src_factor_mode <= cfg_data[3:0];
        REG_DST_FACTOR: cfg.dst_factor_mode <= cfg_data[3:0];
        REG_BLEND_OP:   cfg.blend_op        <= cfg_data[1:0];
        REG_CONSTANT:   cfg.blend_constant  <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Stage 1: pick both factors per channel.
  cbu_factor u_factor (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .fac_valid (fac_valid),
    .fac_ready (fac_ready),
    .fac       (fac)
  );

  // Stages 2 and 3: multiply, then divide by 255.
  cbu_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .fac_valid (fac_valid),
    .fac_ready (fac_ready),
    .fac       (fac),
    .scl_valid (scl_valid),
    .scl_ready (scl_ready),
    .scl       (scl)
  );

  // Stage 4: combine and drive the output register.
  cbu_combine u_combine (
    .clk       (clk),
    .rst       (rst),
    .blend_op  (cfg.blend_op),
    .scl_valid (scl_valid),
    .scl_ready (scl_ready),
    .scl       (scl),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

>>> test/color_blend_unit_core_tb.sv
module color_blend_unit_core_tb;
  import cbu_pkg::*;

  // Codes the package leaves unnamed: the spare factor modes and the fourth op.
  localparam logic [3:0] FM_RSVD_LO = 4'd12;
  localparam logic [3:0] FM_RSVD_A  = 4'd13;
  localparam logic [3:0] FM_RSVD_B  = 4'd14;
  localparam logic [3:0] FM_RSVD_HI = 4'd15;
  localparam logic [1:0] BLEND_OP_SRC_ONLY = 2'd3;

  localparam logic KNOWN = 1'b1;  // row carries its blended pixel
  localparam logic PRED  = 1'b0;  // row is checked against the predictor

  localparam int NUM_DIR      = 20;
  localparam int NUM_SEGMENTS = 24;
  localparam int SEG_ITEMS    = 66;
  localparam int DRAIN_CYCLES = 8;     // pipeline is four stages deep
  localparam int STALL_LIMIT  = 2000;  // cycles without any transaction

  typedef struct packed {
    cfg_t     cfg;
    pix_in_t  pix;
    logic     known;
    pix_out_t res;
  } dir_row_t;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     pix_valid = 1'b0;
  logic     pix_ready;
  pix_in_t  pix       = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  pix_out_t res;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = REG_SRC_FACTOR;
  logic [7:0] cfg_data  = '0;

  // Shadow of the blend registers; starts at the reset setup.
  cfg_t blend_cfg = '{src_factor_mode: RST_SRC_FACTOR, dst_factor_mode: RST_DST_FACTOR,
                      blend_op: OP_SAT_ADD, blend_constant: 8'd0};

  pix_out_t expected_pixels[$];
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int blend_errors = 0;
  int pixels_sent  = 0;
  int pixels_seen  = 0;
  int setups_loaded = 0;

  // Directed stimulus. Columns: src mode, dst mode, op, constant |
  // src r g b a | dst r g b a | known | blended r g b a
  dir_row_t dir_rows [NUM_DIR] = '{
    // reset setup: classic over, opaque source passes through
    {FM_SRC_A, FM_INV_SRC_A, OP_SAT_ADD, 8'd0,
     8'd10, 8'd20, 8'd30, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4, KNOWN, 8'd10, 8'd20, 8'd30, 8'd255},
    // reset setup: transparent source keeps the destination
    {FM_SRC_A, FM_INV_SRC_A, OP_SAT_ADD, 8'd0,
     8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
     KNOWN, 8'd255, 8'd255, 8'd255, 8'd255},
    {FM_ZERO, FM_ZERO, OP_SAT_ADD, 8'd0,
     8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
     KNOWN, 8'd0, 8'd0, 8'd0, 8'd0},
    // add saturates at full scale
    {FM_ONE, FM_ONE, OP_SAT_ADD, 8'd0,
     8'd200, 8'd255, 8'd0, 8'd128, 8'd100, 8'd255, 8'd0, 8'd127,
     KNOWN, 8'd255, 8'd255, 8'd0, 8'd255},
    {FM_ONE, FM_ONE, OP_MAX_COLOR, 8'd0,
     8'd200, 8'd0, 8'd17, 8'd90, 8'd100, 8'd255, 8'd17, 8'd91,
     KNOWN, 8'd200, 8'd255, 8'd17, 8'd91},
    {FM_ONE, FM_ONE, OP_MIN_COLOR, 8'd0,
     8'd200, 8'd0, 8'd17, 8'd90, 8'd100, 8'd255, 8'd17, 8'd91,
     KNOWN, 8'd100, 8'd0, 8'd17, 8'd90},
    // spare op returns the scaled source alone
    {FM_ONE, FM_ONE, BLEND_OP_SRC_ONLY, 8'd0,
     8'd200, 8'd0, 8'd17, 8'd90, 8'd100, 8'd255, 8'd17, 8'd91,
     KNOWN, 8'd200, 8'd0, 8'd17, 8'd90},
    // spare factor modes act as one
    {FM_RSVD_LO, FM_RSVD_HI, OP_SAT_ADD, 8'd0,
     8'd10, 8'd20, 8'd30, 8'd40, 8'd1, 8'd2, 8'd3, 8'd4, KNOWN, 8'd11, 8'd22, 8'd33, 8'd44},
    {FM_CONST, FM_INV_CONST, OP_SAT_ADD, 8'd255,
     8'd50, 8'd60, 8'd70, 8'd80, 8'd9, 8'd9, 8'd9, 8'd9, KNOWN, 8'd50, 8'd60, 8'd70, 8'd80},
    {FM_CONST, FM_INV_CONST, OP_SAT_ADD, 8'd0,
     8'd50, 8'd60, 8'd70, 8'd80, 8'd9, 8'd9, 8'd9, 8'd9, KNOWN, 8'd9, 8'd9, 8'd9, 8'd9},
    {FM_ZERO, FM_ONE, BLEND_OP_SRC_ONLY, 8'd0,
     8'd255, 8'd255, 8'd255, 8'd255, 8'd1, 8'd1, 8'd1, 8'd1, KNOWN, 8'd0, 8'd0, 8'd0, 8'd0},
    {FM_ONE, FM_ONE, OP_MAX_COLOR, 8'd0,
     8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, KNOWN, 8'd0, 8'd0, 8'd0, 8'd0},
    {FM_ONE, FM_ONE, OP_MIN_COLOR, 8'd0,
     8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
     KNOWN, 8'd255, 8'd255, 8'd255, 8'd255},
    // remaining factor modes go through the predictor
    {FM_CONST, FM_CONST, OP_SAT_ADD, 8'd128,
     8'd255, 8'd128, 8'd1, 8'd200, 8'd255, 8'd127, 8'd0, 8'd60, PRED, 32'd0},
    {FM_SRC_COL, FM_INV_SRC_COL, OP_SAT_ADD, 8'd0,
     8'd16, 8'd1, 8'd254, 8'd128, 8'd200, 8'd100, 8'd50, 8'd25, PRED, 32'd0},
    {FM_DST_A, FM_INV_DST_A, OP_SAT_ADD, 8'd0,
     8'd90, 8'd180, 8'd45, 8'd7, 8'd30, 8'd60, 8'd240, 8'd200, PRED, 32'd0},
    {FM_DST_COL, FM_INV_DST_COL, OP_SAT_ADD, 8'd0,
     8'd255, 8'd0, 8'd128, 8'd64, 8'd128, 8'd255, 8'd0, 8'd64, PRED, 32'd0},
    {FM_INV_SRC_A, FM_SRC_A, OP_SAT_ADD, 8'd0,
     8'd255, 8'd255, 8'd255, 8'd100, 8'd255, 8'd255, 8'd255, 8'd0, PRED, 32'd0},
    {FM_RSVD_A, FM_RSVD_B, OP_SAT_ADD, 8'd0,
     8'd200, 8'd100, 8'd0, 8'd255, 8'd100, 8'd200, 8'd255, 8'd1, PRED, 32'd0},
    {FM_SRC_COL, FM_DST_COL, BLEND_OP_SRC_ONLY, 8'd77,
     8'd170, 8'd85, 8'd255, 8'd0, 8'd85, 8'd170, 8'd0, 8'd255, PRED, 32'd0}
  };

  color_blend_unit_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Factor for one channel, as a fraction of 255.
  function automatic int factor_for(input logic [3:0] mode, input int s, input int d,
                                    input int sa, input int da, input int k);
    case (mode)
      FM_ZERO:        return 0;
      FM_ONE:         return 255;
      FM_SRC_COL:     return s;
      FM_INV_SRC_COL: return 255 - s;
      FM_SRC_A:       return sa;
      FM_INV_SRC_A:   return 255 - sa;
      FM_DST_A:       return da;
      FM_INV_DST_A:   return 255 - da;
      FM_DST_COL:     return d;
      FM_INV_DST_COL: return 255 - d;
      FM_CONST:       return k;
      FM_INV_CONST:   return 255 - k;
      default:        return 255;  // spare modes pass the side unscaled
    endcase
  endfunction

  // Blended pixel for one fragment under the given setup.
  function automatic pix_out_t predict_blend(input cfg_t c, input pix_in_t p);
    int src_ch [4];
    int dst_ch [4];
    int blended [4];
    int fs, fd, ss, ds;
    pix_out_t o;
    src_ch = '{int'(p.src_red), int'(p.src_green), int'(p.src_blue), int'(p.src_alpha)};
    dst_ch = '{int'(p.dst_red), int'(p.dst_green), int'(p.dst_blue), int'(p.dst_alpha)};
    for (int i = 0; i < NUM_CH; i++) begin
      fs = factor_for(c.src_factor_mode, src_ch[i], dst_ch[i], src_ch[CH_ALPHA],
                      dst_ch[CH_ALPHA], int'(c.blend_constant));
      fd = factor_for(c.dst_factor_mode, src_ch[i], dst_ch[i], src_ch[CH_ALPHA],
                      dst_ch[CH_ALPHA], int'(c.blend_constant));
      ss = (src_ch[i] * fs) / 255;
      ds = (dst_ch[i] * fd) / 255;
      case (c.blend_op)
        OP_SAT_ADD:   blended[i] = (ss + ds > 255) ? 255 : ss + ds;
        OP_MAX_COLOR: blended[i] = (src_ch[i] > dst_ch[i]) ? src_ch[i] : dst_ch[i];
        OP_MIN_COLOR: blended[i] = (src_ch[i] < dst_ch[i]) ? src_ch[i] : dst_ch[i];
        default:      blended[i] = ss;
      endcase
    end
    o.out_red   = 8'(blended[0]);
    o.out_green = 8'(blended[1]);
    o.out_blue  = 8'(blended[2]);
    o.out_alpha = 8'(blended[3]);
    return o;
  endfunction

  // Lean toward the edge modes so the extremes come up often.
  function automatic logic [3:0] rand_factor_mode();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0:       return FM_ZERO;
        1:       return FM_INV_CONST;
        default: return FM_RSVD_HI;
      endcase
    end
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [7:0] rand_channel();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return 8'($urandom);
  endfunction

  function automatic pix_in_t rand_pixel();
    pix_in_t p;
    p.src_red   = rand_channel();
    p.src_green = rand_channel();
    p.src_blue  = rand_channel();
    p.src_alpha = rand_channel();
    p.dst_red   = rand_channel();
    p.dst_green = rand_channel();
    p.dst_blue  = rand_channel();
    p.dst_alpha = rand_channel();
    return p;
  endfunction

  // Receiver: drop ready at random; one assignment per edge.
  always @(posedge clk) begin
    res_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      blend_errors++;
    end
  endtask

  // Sample at the falling edge: what holds now holds at the next rising edge,
  // so a transaction seen here completes there.
  always @(negedge clk) begin
    pix_out_t want;
    if (!rst && res_valid && res_ready) begin
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        $error("blended pixel with no fragment waiting: %h", res);
        blend_errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_red",   want.out_red,   res.out_red);
        check_field("out_green", want.out_green, res.out_green);
        check_field("out_blue",  want.out_blue,  res.out_blue);
        check_field("out_alpha", want.out_alpha, res.out_alpha);
      end
    end
  end

  // Watchdog: end the run once the channels sit still for too long.
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if ((pix_valid && pix_ready) || (res_valid && res_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Send one fragment; entered and left at a rising edge. Valid stays high on
  // return so back-to-back transactions need no second assignment.
  task automatic send_pixel(input pix_in_t p, input logic known, input pix_out_t res_v);
    pix_out_t want;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix       <= p;
    @(negedge clk);
    while (!pix_ready) @(negedge clk);
    want = known ? res_v : predict_blend(blend_cfg, p);
    expected_pixels = {expected_pixels, want};
    pixels_sent++;
    @(posedge clk);
  endtask

  // Drop valid and wait for every blended pixel still in flight.
  task automatic drain_pipeline();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // Write all four blend registers; spare upper data bits carry noise.
  task automatic load_setup(input cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SRC_FACTOR;
    cfg_data  <= {4'($urandom), c.src_factor_mode};
    @(posedge clk);
    cfg_index <= REG_DST_FACTOR;
    cfg_data  <= {4'($urandom), c.dst_factor_mode};
    @(posedge clk);
    cfg_index <= REG_BLEND_OP;
    cfg_data  <= {6'($urandom), c.blend_op};
    @(posedge clk);
    cfg_index <= REG_CONSTANT;
    cfg_data  <= c.blend_constant;
    @(posedge clk);
    cfg_we <= 1'b0;
    // let the last write land before the next fragment
    @(posedge clk);
    blend_cfg = c;
    setups_loaded++;
  endtask

  initial begin
    cfg_t setup;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; reload the registers only where a row changes them.
    snd_idle_pct = 15;
    rcv_idle_pct = 83;
    for (int r = 0; r < NUM_DIR; r++) begin
      if (dir_rows[r].cfg != blend_cfg) begin
        drain_pipeline();
        load_setup(dir_rows[r].cfg);
      end
      send_pixel(dir_rows[r].pix, dir_rows[r].known, dir_rows[r].res);
    end

    // Random segments, a fresh setup each; advance through three idling regimes.
    for (int s = 0; s < NUM_SEGMENTS; s++) begin
      if (s < NUM_SEGMENTS / 3) begin
        snd_idle_pct = 15;
        rcv_idle_pct = 83;
      end else if (s < 2 * NUM_SEGMENTS / 3) begin
        snd_idle_pct = 83;
        rcv_idle_pct = 15;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      setup.src_factor_mode = rand_factor_mode();
      setup.dst_factor_mode = rand_factor_mode();
      setup.blend_op        = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) setup.blend_constant = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      else setup.blend_constant = 8'($urandom);
      drain_pipeline();
      load_setup(setup);
      for (int n = 0; n < SEG_ITEMS; n++) send_pixel(rand_pixel(), PRED, '0);
    end

    // Let the pipeline empty, then keep watching for stray output.
    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Blended %0d fragments and checked %0d pixels across %0d register setups,",
             pixels_sent, pixels_seen, setups_loaded);
    $display("covering every factor mode, every combine op and both stall patterns.");
    if (blend_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
